@@ sv/bcle_pkg.sv @@
`timescale 1ns / 1ps

package bcle_pkg;

    localparam int CHAR_W = 8;
    localparam int OP_W   = 4;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [OP_W-1:0] OP_INSERT     = 4'd2;
    localparam logic [OP_W-1:0] OP_REMOVE     = 4'd3;
    localparam logic [OP_W-1:0] OP_REPLACE    = 4'd4;
    localparam logic [OP_W-1:0] OP_READ       = 4'd5;
    localparam logic [OP_W-1:0] OP_FIRST      = 4'd6;
    localparam logic [OP_W-1:0] OP_LAST       = 4'd7;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd8;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd9;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd10;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    // Broadcast to every cell of the chain in the cycle an item is accepted.
    typedef struct packed {
        logic              wr;
        logic              up;
        logic              dn;
        logic [CHAR_W-1:0] data;
    } cell_cmd_t;

endpackage

@@ sv/bcle_cell.sv @@
`timescale 1ns / 1ps

module bcle_cell
    import bcle_pkg::*;
#(
    parameter int IDX = 0,
    parameter int AW  = 7
)
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [AW-1:0]     at,
    input  logic [CHAR_W-1:0] left_data,
    input  logic [CHAR_W-1:0] right_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_at,
    output logic [CHAR_W-1:0] data,
    output logic [CHAR_W-1:0] leaf
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic [CHAR_W-1:0] data_reg;
    logic [CHAR_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.wr && (MY_IDX == at))
        begin
            data_next = cmd.data;
        end
        else if (cmd.up && (MY_IDX > at))
        begin
            data_next = left_data;
        end
        else if (cmd.dn && (MY_IDX >= at))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // Only the addressed cell drives its byte into the read-out tree.
    assign leaf = (rd_en && (MY_IDX == rd_at)) ? data_reg : '0;

endmodule

@@ sv/bcle_tree.sv @@
`timescale 1ns / 1ps

module bcle_tree
    import bcle_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int LEVELS = 2
)
(
    input  logic                         clk,
    input  logic [DEPTH-1:0][CHAR_W-1:0] leaves,
    output logic [CHAR_W-1:0]            top
);

    localparam int LEAVES = 1 << (3 * LEVELS);
    localparam int NODES  = (LEAVES - 1) / 7;

    function automatic int lvl_base(input int k);
        int b;
        b = 0;
        for (int m = 1; m < k; m++)
        begin
            b = b + (1 << (3 * (LEVELS - m)));
        end
        return b;
    endfunction

    logic [CHAR_W-1:0] leaf_pad [LEAVES];
    logic [CHAR_W-1:0] node_reg [NODES];

    genvar i, k, j;

    generate
        for (i = 0; i < LEAVES; i++)
        begin : g_pad
            if (i < DEPTH)
            begin : g_real
                assign leaf_pad[i] = leaves[i];
            end
            else
            begin : g_zero
                assign leaf_pad[i] = '0;
            end
        end

        // Registered 8-way OR tree: each level is registered.
        for (k = 1; k <= LEVELS; k++)
        begin : g_lvl
            for (j = 0; j < (1 << (3 * (LEVELS - k))); j++)
            begin : g_node
                localparam int DST = lvl_base(k) + j;
                logic [CHAR_W-1:0] acc;
                if (k == 1)
                begin : g_first
                    always_comb
                    begin
                        acc = '0;
                        for (int t = 0; t < 8; t++)
                        begin
                            acc = acc | leaf_pad[8 * j + t];
                        end
                    end
                end
                else
                begin : g_upper
                    localparam int SRC = lvl_base(k - 1) + 8 * j;
                    always_comb
                    begin
                        acc = '0;
                        for (int t = 0; t < 8; t++)
                        begin
                            acc = acc | node_reg[SRC + t];
                        end
                    end
                end
                always_ff @(posedge clk)
                begin
                    node_reg[DST] <= acc;
                end
            end
        end
    endgenerate

    assign top = node_reg[NODES-1];

endmodule

@@ sv/bounded_char_list_engine_unit.sv @@
`timescale 1ns / 1ps
// Bounded byte list held in a chain of DEPTH cells.
// Input channel (in_valid/in_ready): one request beat carries op, char_in and
// position. Output channel (out_valid/out_ready): one result beat per request
// with char_out, list_length and status.
// Every cell updates in the cycle the request is accepted, so insert and
// remove shift all entries at once. Reads go through a registered 8-way OR
// tree of LEVELS = ceil(log2(DEPTH)/3) levels (2 at DEPTH 64).
// The result is valid once the request has passed the rd_en/rd_at registers
// and the LEVELS registered levels of the tree. One request is in flight at a
// time; a new request is taken in the same cycle its predecessor's result is
// taken.
// Reset empties the list; stored bytes are not cleared and need no sweep.
// While the receiver stalls the result is held steady and no new request is
// accepted.
module bounded_char_list_engine_unit
    import bcle_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [OP_W-1:0]                   op,
    input  logic [CHAR_W-1:0]                 char_in,
    input  logic [$clog2(DEPTH+1)-1:0]        position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [CHAR_W-1:0]                 char_out,
    output logic [$clog2(DEPTH+1)-1:0]        list_length,
    output logic [ST_W-1:0]                   status
);

    localparam int LW     = $clog2(DEPTH + 1);
    localparam int LEVELS = ($clog2(DEPTH) + 2) / 3;
    localparam int CW     = $clog2(LEVELS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);
    localparam logic [CW-1:0] CNT_INIT = CW'(LEVELS - 1);

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [LW-1:0]     length_reg, length_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic              rd_en_reg, rd_en_next;
    logic [LW-1:0]     rd_at_reg, rd_at_next;

    logic              in_fire;
    logic              full;
    logic              empty;
    logic              pos_lt;
    logic              pos_le;
    cell_cmd_t         cmd;
    logic [LW-1:0]     at;

    logic [CHAR_W-1:0]            cell_data [DEPTH];
    logic [DEPTH-1:0][CHAR_W-1:0] leaf_bus;

    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && out_ready);
    assign in_fire  = in_valid && in_ready;

    assign full   = (length_reg == FULL_LEN);
    assign empty  = (length_reg == '0);
    assign pos_lt = (position < length_reg);
    assign pos_le = (position <= length_reg);

    // Request decode. A failed request leaves the chain and the length alone.
    always_comb
    begin
        cmd         = '0;
        cmd.data    = char_in;
        at          = '0;
        length_next = length_reg;
        status_next = ST_OK;
        rd_en_next  = 1'b0;
        rd_at_next  = '0;
        case (op)
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.wr      = 1'b1;
                    at          = length_reg;
                    length_next = length_reg + LW'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.wr      = 1'b1;
                    cmd.up      = 1'b1;
                    length_next = length_reg + LW'(1);
                end
            end
            OP_INSERT:
            begin
                if (!pos_le)
                begin
                    status_next = ST_RANGE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.wr      = 1'b1;
                    cmd.up      = 1'b1;
                    at          = position;
                    length_next = length_reg + LW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (!pos_lt)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.dn      = 1'b1;
                    at          = position;
                    length_next = length_reg - LW'(1);
                end
            end
            OP_REPLACE:
            begin
                if (!pos_lt)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.wr = 1'b1;
                    at     = position;
                end
            end
            OP_READ:
            begin
                if (!pos_lt)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rd_en_next = 1'b1;
                    rd_at_next = position;
                end
            end
            OP_FIRST:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en_next = 1'b1;
                end
            end
            OP_LAST:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en_next = 1'b1;
                    rd_at_next = length_reg - LW'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.dn      = 1'b1;
                    length_next = length_reg - LW'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    length_next = length_reg - LW'(1);
                end
            end
            OP_CLEAR:
            begin
                length_next = '0;
            end
            default:
            begin
                length_next = length_reg;
            end
        endcase
        if (!in_fire)
        begin
            cmd.wr = 1'b0;
            cmd.up = 1'b0;
            cmd.dn = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_BUSY;
                    cnt_next   = CNT_INIT;
                end
            end
            S_BUSY:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_OUT:
            begin
                if (in_fire)
                begin
                    state_next = S_BUSY;
                    cnt_next   = CNT_INIT;
                end
                else if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            length_reg <= '0;
            rd_en_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (in_fire)
            begin
                length_reg <= length_next;
                rd_en_reg  <= rd_en_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_at_reg <= rd_at_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [CHAR_W-1:0] left_in;
            logic [CHAR_W-1:0] right_in;
            if (i == 0)
            begin : g_head
                assign left_in = '0;
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_tail
                assign right_in = '0;
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[i+1];
            end
            bcle_cell #(
                .IDX (i),
                .AW  (LW)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .at         (at),
                .left_data  (left_in),
                .right_data (right_in),
                .rd_en      (rd_en_reg),
                .rd_at      (rd_at_reg),
                .data       (cell_data[i]),
                .leaf       (leaf_bus[i])
            );
        end
    endgenerate

    bcle_tree #(
        .DEPTH  (DEPTH),
        .LEVELS (LEVELS)
    ) u_tree (
        .clk    (clk),
        .leaves (leaf_bus),
        .top    (char_out)
    );

    assign out_valid   = (state_reg == S_OUT);
    assign list_length = length_reg;
    assign status      = status_reg;

endmodule

@@ sv/bcle_checker.sv @@
`timescale 1ns / 1ps

module bcle_checker
    import bcle_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [OP_W-1:0]            op,
    input logic [CHAR_W-1:0]          char_in,
    input logic [$clog2(DEPTH+1)-1:0] position,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [CHAR_W-1:0]          char_out,
    input logic [$clog2(DEPTH+1)-1:0] list_length,
    input logic [ST_W-1:0]            status
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);

    // A result beat that is stalled stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out)
            && $stable(list_length) && $stable(status))
        else $error("stalled result beat changed");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> list_length <= FULL_LEN)
        else $error("list length beyond capacity");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> list_length == FULL_LEN)
        else $error("full status on a list that is not full");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> list_length == '0)
        else $error("empty status on a list that is not empty");

    // A byte only comes back from a successful read.
    a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_out != '0) |-> status == ST_OK && list_length != '0)
        else $error("byte returned with an error status");

endmodule

bind bounded_char_list_engine_unit bcle_checker #(.DEPTH(DEPTH)) u_bcle_checker (.*);
